### src/olst_pkg.sv
// ----------------------------------------------------------------------------
// olst_pkg - shared types and constants for the ordered list engine
// Sizes, command and status codes, and the controller state type.
// ----------------------------------------------------------------------------
`default_nettype none

package olst_pkg;

  // list capacity and derived widths
  localparam int DEPTH = 32;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int CNT_W = 6;
  localparam int VAL_W = 32;

  // command codes
  localparam logic [2:0] CMD_APPEND  = 3'd0;
  localparam logic [2:0] CMD_PREPEND = 3'd1;
  localparam logic [2:0] CMD_SORTED  = 3'd2;
  localparam logic [2:0] CMD_DEL_FRT = 3'd3;
  localparam logic [2:0] CMD_DEL_END = 3'd4;
  localparam logic [2:0] CMD_DEL_KEY = 3'd5;
  localparam logic [2:0] CMD_RD_FWD  = 3'd6;
  localparam logic [2:0] CMD_RD_REV  = 3'd7;

  // status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;
  localparam logic [1:0] STAT_NOKEY = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FIN
  } state_t;

endpackage

`default_nettype wire

### src/olst_if.sv
// ----------------------------------------------------------------------------
// olst_if - stream channels of the ordered list engine
// Command channel and result channel, each with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface olst_cmd_if;
  logic               valid;
  logic               ready;
  logic [2:0]         command;
  logic signed [31:0] value;

  modport source (output valid, command, value, input ready);
  modport sink   (input valid, command, value, output ready);
endinterface

interface olst_res_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [31:0] element;
  logic               is_last;
  logic [5:0]         count;

  modport source (output valid, status, element, is_last, count, input ready);
  modport sink   (input valid, status, element, is_last, count, output ready);
endinterface

`default_nettype wire

### src/olst_ram.sv
// ----------------------------------------------------------------------------
// olst_ram - generic simple dual-port RAM
// One synchronous write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module olst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### src/ordered_list_engine_top.sv
// ----------------------------------------------------------------------------
// ordered_list_engine_top - bounded ordered list of signed 32-bit values
// Elements live in one RAM, front first; a walker reads, shifts and emits.
// ----------------------------------------------------------------------------
// Usage:
//   cmd channel: one command (append, prepend, sorted insert, delete front,
//   delete end, delete key, read forward, read reverse) plus a value per
//   transfer. res channel: status, element, is_last and count per transfer.
//   Non-readout commands give one result; a readout gives one result per
//   element, is_last set on the final one (one empty-status result if the
//   list is empty).
//   Timing: one command at a time. Delete end and rejected commands skip the
//   walk and go straight to the final status. Other commands walk the RAM
//   one entry per cycle, except while a readout is paused (see below), with
//   registered read data. The walk is set by the single RAM read port.
//   A pending result sits in an output register; the next command is taken
//   while it waits. A stalled receiver pauses a readout walk in place, and
//   other commands wait with their result until the register frees up.
//   Reset (rst, synchronous) empties the list; RAM contents are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module ordered_list_engine_top
  import olst_pkg::*;
(
  input wire logic  clk,
  input wire logic  rst,
  olst_cmd_if.sink  cmd,
  olst_res_if.source res
);

  // control and walk registers
  state_t             state, state_next;
  logic [2:0]         cmd_r;
  logic signed [31:0] val_r;
  logic [CW-1:0]      count;
  logic [CW-1:0]      ipos;
  logic [CW-1:0]      fpos;
  logic               idone;
  logic [CW-1:0]      ppos;
  logic               pvalid;
  logic               plast;
  logic               ins_act;
  logic               found;
  logic [31:0]        carry;
  logic [1:0]         rstat;

  // output register
  logic               ov;
  logic [1:0]         o_status;
  logic [31:0]        o_elem;
  logic               o_last;
  logic [CW-1:0]      o_count;

  // RAM port
  logic               we;
  logic [AW-1:0]      waddr;
  logic [31:0]        wdata;
  logic [AW-1:0]      raddr;
  logic [31:0]        rdata;

  logic is_read, is_ins, out_free, adv, proc, ins_hit, del_hit;
  logic acc, in_ins, full, empty, ov_set;

  olst_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // decode
  assign is_read  = (cmd_r == CMD_RD_FWD) || (cmd_r == CMD_RD_REV);
  assign is_ins   = (cmd_r == CMD_APPEND) || (cmd_r == CMD_PREPEND) || (cmd_r == CMD_SORTED);
  assign in_ins   = (cmd.command == CMD_APPEND) || (cmd.command == CMD_PREPEND) ||
                    (cmd.command == CMD_SORTED);
  assign full     = (count == CW'(DEPTH));
  assign empty    = (count == '0);
  assign out_free = !ov || res.ready;
  assign acc      = cmd.valid && cmd.ready;

  // walk step: a readout pauses while the output register is blocked
  assign adv  = !(is_read && pvalid && !out_free);
  assign proc = (state == ST_WALK) && pvalid && adv;

  assign ins_hit = !ins_act && ((ppos == count) || (cmd_r == CMD_PREPEND) ||
                   ((cmd_r == CMD_SORTED) && !($signed(rdata) < val_r)));
  assign del_hit = !found && ((cmd_r == CMD_DEL_FRT) || ($signed(rdata) == val_r));

  // output register load: readout element or final status
  assign ov_set = (proc && is_read) || ((state == ST_FIN) && out_free);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (acc) begin
          if (cmd.command == CMD_DEL_END || (in_ins && full) || (!in_ins && empty)) begin
            state_next = ST_FIN;
          end else begin
            state_next = ST_WALK;
          end
        end
      end
      ST_WALK: begin
        if (proc && plast) begin
          state_next = is_read ? ST_IDLE : ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // RAM controls and handshake outputs
  always_comb begin
    cmd.ready = (state == ST_IDLE);
    we    = proc && ((is_ins && (ins_act || ins_hit)) || (!is_ins && !is_read && found));
    waddr = is_ins ? ppos[AW-1:0] : AW'(ppos - CW'(1));
    wdata = is_ins ? (ins_act ? carry : val_r) : rdata;
    raddr = ((state == ST_WALK) && !adv) ? ppos[AW-1:0] : ipos[AW-1:0];
  end

  assign res.valid   = ov;
  assign res.status  = o_status;
  assign res.element = o_elem;
  assign res.is_last = o_last;
  assign res.count   = CNT_W'(o_count);

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      count  <= '0;
      pvalid <= 1'b0;
      ov     <= 1'b0;
    end else begin
      state <= state_next;
      if (ov_set) begin
        ov <= 1'b1;
      end else if (res.ready) begin
        ov <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (acc) begin
            pvalid <= 1'b0;
            if (cmd.command == CMD_DEL_END && !empty) begin
              count <= count - CW'(1);
            end
          end
        end
        ST_WALK: begin
          // last entry issued clears pvalid once it is processed
          if (adv) begin
            pvalid <= !idone;
          end
          if (proc && plast) begin
            if (is_ins) begin
              count <= count + CW'(1);
            end else if (!is_read && (found || del_hit)) begin
              count <= count - CW'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  // walk datapath and result payload
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (acc) begin
          cmd_r   <= cmd.command;
          val_r   <= cmd.value;
          ins_act <= 1'b0;
          found   <= 1'b0;
          idone   <= 1'b0;
          ipos    <= (cmd.command == CMD_APPEND) ? count :
                     (cmd.command == CMD_RD_REV) ? count - CW'(1) : '0;
          fpos    <= in_ins ? count :
                     (cmd.command == CMD_RD_REV) ? '0 : count - CW'(1);
          if (in_ins && full) begin
            rstat <= STAT_FULL;
          end else if (!in_ins && empty) begin
            rstat <= STAT_EMPTY;
          end else begin
            rstat <= STAT_OK;
          end
        end
      end
      ST_WALK: begin
        if (adv && !idone) begin
          ppos  <= ipos;
          plast <= (ipos == fpos);
          idone <= (ipos == fpos);
          ipos  <= (cmd_r == CMD_RD_REV) ? ipos - CW'(1) : ipos + CW'(1);
        end
        if (proc) begin
          if (is_ins && (ins_act || ins_hit)) begin
            ins_act <= 1'b1;
            carry   <= rdata;
          end
          if (!is_ins && !is_read && del_hit) begin
            found <= 1'b1;
          end
          if (is_read) begin
            o_status <= STAT_OK;
            o_elem   <= rdata;
            o_last   <= plast;
            o_count  <= count;
          end
          if (plast && !is_read && !is_ins && !(found || del_hit)) begin
            rstat <= STAT_NOKEY;
          end
        end
      end
      ST_FIN: begin
        if (out_free) begin
          o_status <= rstat;
          o_elem   <= '0;
          o_last   <= 1'b1;
          o_count  <= count;
        end
      end
      default: ;
    endcase
  end

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH)) else $error("list count beyond capacity");

  a_no_idle_write: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !we) else $error("RAM write while idle");

  a_read_in_range: assert property (@(posedge clk) disable iff (rst)
    (proc && is_read) |-> (ppos < count)) else $error("readout beyond list end");

  a_fin_waits: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIN && !out_free) |=> (state == ST_FIN))
    else $error("result lost while receiver stalled");

endmodule

`default_nettype wire
